### sv/stick_square_to_disc_polar_macros.svh
// ----------------------------------------------------------------------------
// Stick square-to-disc assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef STICK_SQUARE_TO_DISC_POLAR_MACROS_SVH
`define STICK_SQUARE_TO_DISC_POLAR_MACROS_SVH

// Checked on every rising edge outside reset.
`define SSDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SSDP_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/ssdp_pkg.sv
// ----------------------------------------------------------------------------
// Stick square-to-disc package
// Widths, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ssdp_pkg;

  localparam int SQ_IN_W    = 30;  // radicand width
  localparam int SQ_OUT_W   = 15;  // root width
  localparam int SQ_REM_W   = 32;  // remainder working width
  localparam int SQ_STAGES  = SQ_OUT_W;
  localparam int SQ_LAT     = SQ_STAGES + 1;

  localparam int CORDIC_STEPS = 14;
  localparam int CORDIC_W     = 25;
  localparam int ANGLE_W      = 16;

  localparam logic signed [ANGLE_W-1:0] ANG_PI      = 16'sd25736;
  localparam logic signed [ANGLE_W-1:0] ANG_HALF_PI = 16'sd12868;
  localparam logic [14:0]               RADIUS_MAX  = 15'd16384;

  localparam logic signed [ANGLE_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    16'sd6434, 16'sd3798, 16'sd2007, 16'sd1019, 16'sd511, 16'sd256, 16'sd128,
    16'sd64, 16'sd32, 16'sd16, 16'sd8, 16'sd4, 16'sd2, 16'sd1
  };

endpackage

### sv/ssdp_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined square root
// One result bit per stage, then a round-to-nearest stage.
// ----------------------------------------------------------------------------
module ssdp_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ssdp_pkg::SQ_IN_W-1:0]  radicand,
  output logic [ssdp_pkg::SQ_OUT_W-1:0] root
);
  import ssdp_pkg::*;

  logic [SQ_REM_W-1:0] rem [SQ_STAGES];
  logic [SQ_OUT_W-1:0] q   [SQ_STAGES];

  genvar j;
  generate
    for (j = 0; j < SQ_STAGES; j++) begin : g_stage
      localparam int K = SQ_STAGES - 1 - j;
      logic [SQ_REM_W-1:0] rem_in;
      logic [SQ_OUT_W-1:0] q_in;
      logic [SQ_REM_W-1:0] trial;
      if (j == 0) begin : g_first
        assign rem_in = SQ_REM_W'(radicand);
        assign q_in   = '0;
      end else begin : g_rest
        assign rem_in = rem[j-1];
        assign q_in   = q[j-1];
      end
      // Growth of the square when bit K is set: 2*q*2^K + 4^K.
      assign trial = (SQ_REM_W'(q_in) << (K + 1)) + (SQ_REM_W'(1) << (2 * K));
      always_ff @(posedge clk) begin
        if (en) begin
          if (rem_in >= trial) begin
            rem[j] <= rem_in - trial;
            q[j]   <= q_in | (SQ_OUT_W'(1) << K);
          end else begin
            rem[j] <= rem_in;
            q[j]   <= q_in;
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem[SQ_STAGES-1] > SQ_REM_W'(q[SQ_STAGES-1])) begin
        root <= q[SQ_STAGES-1] + SQ_OUT_W'(1);
      end else begin
        root <= q[SQ_STAGES-1];
      end
    end
  end

endmodule

### sv/ssdp_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC vectoring
// Angle of a first-quadrant point, one rotation step per register stage.
// ----------------------------------------------------------------------------
module ssdp_cordic (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [ssdp_pkg::CORDIC_W-1:0] x_in,
  input  logic signed [ssdp_pkg::CORDIC_W-1:0] y_in,
  output logic signed [ssdp_pkg::ANGLE_W-1:0]  z_out
);
  import ssdp_pkg::*;

  logic signed [CORDIC_W-1:0] x [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y [CORDIC_STEPS];
  logic signed [ANGLE_W-1:0]  z [CORDIC_STEPS];

  genvar i;
  generate
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CORDIC_W-1:0] xi, yi;
      logic signed [ANGLE_W-1:0]  zi;
      if (i == 0) begin : g_first
        assign xi = x_in;
        assign yi = y_in;
        assign zi = '0;
      end else begin : g_rest
        assign xi = x[i-1];
        assign yi = y[i-1];
        assign zi = z[i-1];
      end
      // A point already on the axis passes through unchanged.
      always_ff @(posedge clk) begin
        if (en) begin
          if (yi > 0) begin
            x[i] <= xi + (yi >>> i);
            y[i] <= yi - (xi >>> i);
            z[i] <= zi + ATAN_TAB[i];
          end else if (yi < 0) begin
            x[i] <= xi - (yi >>> i);
            y[i] <= yi + (xi >>> i);
            z[i] <= zi - ATAN_TAB[i];
          end else begin
            x[i] <= xi;
            y[i] <= yi;
            z[i] <= zi;
          end
        end
      end
    end
  endgenerate

  assign z_out = z[CORDIC_STEPS-1];

endmodule

### sv/stick_square_to_disc_polar.sv
// ----------------------------------------------------------------------------
// Stick square-to-disc mapping with polar output
// Normalises a stick reading, maps the square onto the disc and gives
// radius and angle.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless the output stalls, and keeps
// the results in order. Three 16-stage square-root pipelines (radius and
// the two disc scale factors) run side by side, followed by a 14-stage CORDIC
// pipeline for the angle. When the output item is not taken the whole pipeline
// holds, so s_tready follows m_tready whenever an item waits at the output.
module stick_square_to_disc_polar (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // axis_horizontal [7:0], axis_vertical [15:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata   // norm_x, norm_y, radius, angle, zero pad
);
  import ssdp_pkg::*;

  localparam int LAT = 4 + SQ_LAT + CORDIC_STEPS;

  logic           en;
  logic [LAT-1:0] valid;

  assign en       = !valid[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = valid[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[LAT-2:0], s_tvalid};
    end
  end

  // Stage 1: centre the axes and square them.
  logic signed [8:0]  a_in, b_in;
  logic signed [17:0] aa_full, bb_full;
  logic signed [8:0]  a1, b1;
  logic [14:0]        aa1, bb1;

  assign a_in    = $signed({1'b0, s_tdata[7:0]}) - 9'sd128;
  assign b_in    = 9'sd128 - $signed({1'b0, s_tdata[15:8]});
  assign aa_full = a_in * a_in;
  assign bb_full = b_in * b_in;

  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= a_in;
      b1  <= b_in;
      aa1 <= aa_full[14:0];
      bb1 <= bb_full[14:0];
    end
  end

  // Stage 2: radicands for the radius and both scale factors.
  logic [29:0]         prod;
  logic [15:0]         sum_sq;
  logic signed [8:0]   a2, b2;
  logic [SQ_IN_W-1:0]  m2, rx2, ry2;

  assign prod   = aa1 * bb1;
  assign sum_sq = 16'(aa1) + 16'(bb1);

  always_ff @(posedge clk) begin
    if (en) begin
      a2  <= a1;
      b2  <= b1;
      m2  <= {sum_sq, 14'b0} - prod;
      rx2 <= {16'd32768 - 16'(bb1), 14'b0};
      ry2 <= {16'd32768 - 16'(aa1), 14'b0};
    end
  end

  logic [SQ_OUT_W-1:0] r_root, sx_root, sy_root;

  ssdp_sqrt u_sqrt_r  (.clk(clk), .en(en), .radicand(m2),  .root(r_root));
  ssdp_sqrt u_sqrt_sx (.clk(clk), .en(en), .radicand(rx2), .root(sx_root));
  ssdp_sqrt u_sqrt_sy (.clk(clk), .en(en), .radicand(ry2), .root(sy_root));

  logic signed [8:0] sa [SQ_LAT];
  logic signed [8:0] sb [SQ_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sa[0] <= a2;
      sb[0] <= b2;
      for (int k = 1; k < SQ_LAT; k++) begin
        sa[k] <= sa[k-1];
        sb[k] <= sb[k-1];
      end
    end
  end

  // Stage 3: scale the point and fold it into the first quadrant.
  logic signed [8:0]  a_s, b_s, abs_a9, abs_b9;
  logic [22:0]        px_abs, py_abs;
  logic signed [8:0]  a3, b3;
  logic [14:0]        r3;
  logic signed [CORDIC_W-1:0] x3, y3;

  assign a_s    = sa[SQ_LAT-1];
  assign b_s    = sb[SQ_LAT-1];
  assign abs_a9 = a_s[8] ? -a_s : a_s;
  assign abs_b9 = b_s[8] ? -b_s : b_s;
  assign px_abs = abs_a9[7:0] * sx_root;
  assign py_abs = abs_b9[7:0] * sy_root;

  always_ff @(posedge clk) begin
    if (en) begin
      a3 <= a_s;
      b3 <= b_s;
      r3 <= (r_root > RADIUS_MAX) ? RADIUS_MAX : r_root;
      x3 <= $signed(CORDIC_W'(px_abs));
      y3 <= $signed(CORDIC_W'(py_abs));
    end
  end

  logic signed [ANGLE_W-1:0] z_q;

  ssdp_cordic u_cordic (.clk(clk), .en(en), .x_in(x3), .y_in(y3), .z_out(z_q));

  logic signed [8:0] ca [CORDIC_STEPS];
  logic signed [8:0] cb [CORDIC_STEPS];
  logic [14:0]       cr [CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      ca[0] <= a3;
      cb[0] <= b3;
      cr[0] <= r3;
      for (int k = 1; k < CORDIC_STEPS; k++) begin
        ca[k] <= ca[k-1];
        cb[k] <= cb[k-1];
        cr[k] <= cr[k-1];
      end
    end
  end

  // Output stage: clamp, restore the quadrant and handle the axes.
  logic signed [8:0]         a_o, b_o;
  logic signed [ANGLE_W-1:0] t_clamp, t_mirror, angle_next;

  assign a_o = ca[CORDIC_STEPS-1];
  assign b_o = cb[CORDIC_STEPS-1];

  always_comb begin
    if (z_q < 0) begin
      t_clamp = '0;
    end else if (z_q > ANG_HALF_PI) begin
      t_clamp = ANG_HALF_PI;
    end else begin
      t_clamp = z_q;
    end
    t_mirror = a_o[8] ? (ANG_PI - t_clamp) : t_clamp;
    // On the horizontal axis the vertical part counts as a negative zero.
    if (b_o == 9'sd0) begin
      angle_next = a_o[8] ? -ANG_PI : '0;
    end else if (a_o == 9'sd0) begin
      angle_next = b_o[8] ? -ANG_HALF_PI : ANG_HALF_PI;
    end else begin
      angle_next = b_o[8] ? -t_mirror : t_mirror;
    end
  end

  logic signed [15:0] norm_x, norm_y;
  logic [14:0]        radius;
  logic signed [15:0] angle;

  always_ff @(posedge clk) begin
    if (en) begin
      norm_x <= {{7{a_o[8]}}, a_o[7:0], 1'b0} <<< 6;
      norm_y <= {{7{b_o[8]}}, b_o[7:0], 1'b0} <<< 6;
      radius <= cr[CORDIC_STEPS-1];
      angle  <= angle_next;
    end
  end

  assign m_tdata = {1'b0, angle, radius, norm_y, norm_x};

endmodule

### sv/ssdp_checker.sv
// ----------------------------------------------------------------------------
// Stick square-to-disc port checker
// Watches the top-level ports for output ranges and stall behaviour.
// ----------------------------------------------------------------------------
`include "stick_square_to_disc_polar_macros.svh"

module ssdp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  // A stalled result item must stay unchanged.
  `SSDP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output changed while stalled")

  `SSDP_ASSERT(a_radius_range, m_tvalid |-> m_tdata[46:32] <= 15'd16384, "radius above one")

  `SSDP_ASSERT(a_angle_range, m_tvalid |-> ($signed(m_tdata[62:47]) >= -16'sd25736) && ($signed(m_tdata[62:47]) <= 16'sd25736), "angle out of range")

  // The first edge after reset is released must still show an empty output.
  `SSDP_ASSERT_NR(a_reset_empty, $past(rst) && !rst |-> !m_tvalid, "result shown straight after reset")

endmodule

bind stick_square_to_disc_polar ssdp_checker u_ssdp_checker (.*);
